// ===== rtl/hex_ascii_frame_decoder_assert.svh =====
// Assertion macros shared by the frame decoder RTL
`ifndef HEX_ASCII_FRAME_DECODER_ASSERT_SVH
`define HEX_ASCII_FRAME_DECODER_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low
`define HAFD_ASSERT_IMP(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low
`define HAFD_ASSERT_NXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/hafd_pkg.sv =====
// Constants and helpers for the ASCII hex frame decoder
package hafd_pkg;

    // Default receive buffer size in characters
    localparam int BUFFER_BYTES_DEFAULT = 64;

    // Decoded head bytes kept per frame
    localparam int HEAD_DEPTH = 8;
    localparam int HEAD_W     = $clog2(HEAD_DEPTH);

    // Character codes
    localparam logic [7:0] CH_COLON   = 8'h3A;
    localparam logic [7:0] CH_NEWLINE = 8'h0A;
    localparam logic [7:0] CH_NUL     = 8'h00;
    localparam logic [7:0] CH_ASYNC   = 8'h41;

    // Expected byte sum of a good frame
    localparam logic [7:0] SUM_MATCH = 8'h55;

    // Uppercase hex digit to nibble; anything else reads as zero
    function automatic logic [3:0] hex_nibble(input logic [7:0] c);
        if (c >= 8'h30 && c <= 8'h39)
        begin
            return c[3:0];
        end
        if (c >= 8'h41 && c <= 8'h46)
        begin
            return 4'(c[3:0] + 4'd9);
        end
        return 4'd0;
    endfunction

endpackage

// ===== rtl/hex_ascii_frame_decoder.sv =====
// ASCII hex frame decoder: colon-to-newline frames, 8-bit sum check
//
//  channel | direction | handshake             | payload
//  --------+-----------+-----------------------+--------------------------------------
//  in      | sink      | in_valid / in_ready   | rx_char
//  out     | source    | out_valid / out_ready | command, register_id, flags, value,
//          |           |                       | payload_len
//
// One character word per cycle unless a result stalls; each result is registered.
// Rate is set by the single decode step between the input register and result register.
// Asynchronous reset clears frame state, head bytes and both valid flags.
// A stalled result holds the input register, which then drops in_ready.
// Only a newline that closes a good frame gives a result; other words give none.
`include "hex_ascii_frame_decoder_assert.svh"

module hex_ascii_frame_decoder #(
    parameter int BUFFER_BYTES = hafd_pkg::BUFFER_BYTES_DEFAULT
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  rx_char,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  command,
    output logic [15:0] register_id,
    output logic [7:0]  flags,
    output logic [31:0] value,
    output logic [6:0]  payload_len
);
    import hafd_pkg::*;

    localparam int              CNT_W = $clog2(BUFFER_BYTES);
    localparam logic [CNT_W-1:0] LIMIT = CNT_W'(BUFFER_BYTES - 2);

    // Input register
    logic             s1_valid_reg;
    logic [7:0]       char_reg;
    logic             s1_fire;

    // Frame state
    logic             in_frame_reg,  in_frame_next;
    logic [CNT_W-1:0] char_count_reg, char_count_next;
    logic [7:0]       second_char_reg, second_char_next;
    logic [3:0]       pend_reg,      pend_next;
    logic [7:0]       sum_reg,       sum_next;
    logic [6:0]       byte_cnt_reg,  byte_cnt_next;
    logic             stopped_reg,   stopped_next;
    logic [7:0]       head_reg  [HEAD_DEPTH];
    logic [7:0]       head_next [HEAD_DEPTH];
    logic             emit;

    // Result register
    logic             out_valid_reg;
    logic [7:0]       command_reg;
    logic [15:0]      register_id_reg;
    logic [7:0]       flags_reg;
    logic [31:0]      value_reg;
    logic [6:0]       payload_len_reg;

    // Handshake
    assign s1_fire  = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !s1_valid_reg || s1_fire;

    // Decode one character against the frame state
    always_comb
    begin
        logic       is_colon;
        logic       active;
        logic [7:0] b;

        is_colon        = (char_reg == CH_COLON);
        in_frame_next   = in_frame_reg || is_colon;
        char_count_next = is_colon ? '0 : char_count_reg;
        pend_next       = is_colon ? 4'd0 : pend_reg;
        sum_next        = is_colon ? 8'd0 : sum_reg;
        byte_cnt_next   = is_colon ? 7'd0 : byte_cnt_reg;
        stopped_next    = is_colon ? 1'b0 : stopped_reg;
        second_char_next = second_char_reg;
        head_next       = head_reg;
        emit            = 1'b0;
        b               = {pend_next, hex_nibble(char_reg)};

        active = in_frame_next && (char_count_next < LIMIT);
        if (active)
        begin
            if (char_count_next == CNT_W'(1))
            begin
                second_char_next = char_reg;
            end
            // Pair nibbles into bytes until conversion stops
            if (!stopped_next)
            begin
                if (!char_count_next[0])
                begin
                    if (char_reg == CH_NEWLINE || char_reg == CH_NUL)
                    begin
                        stopped_next = 1'b1;
                    end
                    else
                    begin
                        pend_next = hex_nibble(char_reg);
                    end
                end
                else
                begin
                    if (byte_cnt_next < 7'(HEAD_DEPTH))
                    begin
                        head_next[byte_cnt_next[HEAD_W-1:0]] = b;
                    end
                    sum_next      = sum_next + b;
                    byte_cnt_next = byte_cnt_next + 7'd1;
                end
            end
            char_count_next = char_count_next + CNT_W'(1);
            // Newline closes the frame
            if (char_reg == CH_NEWLINE)
            begin
                in_frame_next = 1'b0;
                emit = (second_char_next != CH_ASYNC) && (sum_next == SUM_MATCH)
                       && (byte_cnt_next != 7'd0);
            end
        end
    end

    // Control and frame state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
            in_frame_reg    <= 1'b0;
            char_count_reg  <= '0;
            second_char_reg <= 8'd0;
            pend_reg        <= 4'd0;
            sum_reg         <= 8'd0;
            byte_cnt_reg    <= 7'd0;
            stopped_reg     <= 1'b0;
            for (int i = 0; i < HEAD_DEPTH; i++)
            begin
                head_reg[i] <= 8'd0;
            end
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_fire)
            begin
                s1_valid_reg <= 1'b0;
            end

            if (s1_fire && emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end

            if (s1_fire)
            begin
                in_frame_reg    <= in_frame_next;
                char_count_reg  <= char_count_next;
                second_char_reg <= second_char_next;
                pend_reg        <= pend_next;
                sum_reg         <= sum_next;
                byte_cnt_reg    <= byte_cnt_next;
                stopped_reg     <= stopped_next;
                head_reg        <= head_next;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            char_reg <= rx_char;
        end
        if (s1_fire && emit)
        begin
            command_reg     <= head_next[0];
            register_id_reg <= {head_next[2], head_next[1]};
            flags_reg       <= head_next[3];
            value_reg       <= {head_next[7], head_next[6], head_next[5], head_next[4]};
            payload_len_reg <= byte_cnt_next - 7'd1;
        end
    end

    assign out_valid   = out_valid_reg;
    assign command     = command_reg;
    assign register_id = register_id_reg;
    assign flags       = flags_reg;
    assign value       = value_reg;
    assign payload_len = payload_len_reg;

    // Checks
    `HAFD_ASSERT_IMP(a_count_bound, 1'b1, char_count_reg <= LIMIT,
        "character count past buffer limit")
    `HAFD_ASSERT_IMP(a_emit_on_newline, s1_fire && emit, char_reg == CH_NEWLINE,
        "result raised by a word other than newline")
    `HAFD_ASSERT_NXT(a_colon_opens, s1_fire && char_reg == CH_COLON,
        in_frame_reg && char_count_reg == CNT_W'(1), "colon did not open a frame")
    `HAFD_ASSERT_NXT(a_stall_holds, s1_valid_reg && out_valid_reg && !out_ready,
        s1_valid_reg && $stable(char_reg), "input register lost a stalled word")

endmodule

// ===== test/hex_ascii_frame_decoder_tb.sv =====
// Self-checking testbench for the ASCII hex frame decoder
`timescale 1ns / 100ps

module hex_ascii_frame_decoder_tb;

    import hafd_pkg::*;

    // Characters used when building frames
    localparam logic [7:0] CH_DIGIT0  = 8'h30;
    localparam logic [7:0] CH_LETTERA = 8'h41;
    localparam logic [7:0] CH_TOP     = 8'hFF;

    localparam int FRAME_BUF   = BUFFER_BYTES_DEFAULT;
    localparam int CHAR_TARGET = 1350;
    localparam int CYCLE_LIMIT = 200000;
    localparam int IDLE_PCT    = 17;
    localparam int HOLD_AT     = 300;
    localparam int HOLD_CYCLES = 300;
    localparam int QUIET_AT    = 1000;
    localparam int CALM_LO     = 600;
    localparam int CALM_HI     = 900;

    // One decoded frame as seen on the result side
    typedef struct packed {
        logic [7:0]  command;
        logic [15:0] register_id;
        logic [7:0]  flags;
        logic [31:0] value;
        logic [6:0]  payload_len;
    } frame_result_t;

    // Frame decode predictor plus the queue of frames still to come out
    class frame_scoreboard;
        logic          in_frame;
        logic [7:0]    char_count;
        logic [7:0]    second_char;
        logic [3:0]    high_nibble;
        logic [7:0]    byte_sum;
        logic [6:0]    byte_count;
        logic          halted;
        logic [7:0]    head[HEAD_DEPTH];
        frame_result_t expected_frames[$];
        int            chars_noted;
        int            frames_checked;
        int            errors;

        function new();
            in_frame    = 1'b0;
            char_count  = '0;
            second_char = '0;
            high_nibble = '0;
            byte_sum    = '0;
            byte_count  = '0;
            halted      = 1'b0;
            foreach (head[i])
            begin
                head[i] = '0;
            end
            chars_noted    = 0;
            frames_checked = 0;
            errors         = 0;
        endfunction

        // Uppercase hex only; everything else is worth zero
        function logic [3:0] digit_value(logic [7:0] c);
            if (c >= CH_DIGIT0 && c < CH_DIGIT0 + 8'd10)
            begin
                return 4'(c - CH_DIGIT0);
            end
            if (c >= CH_LETTERA && c < CH_LETTERA + 8'd6)
            begin
                return 4'(c - CH_LETTERA + 8'd10);
            end
            return 4'd0;
        endfunction

        task report(string msg);
            errors++;
            $display("[%0t] MISMATCH: %s", $realtime, msg);
        endtask

        // Advance the decoder state by one accepted character word
        function void predict_char(logic [7:0] c);
            logic [7:0]    pos;
            logic [7:0]    b;
            frame_result_t r;
            chars_noted++;
            if (c == CH_COLON)
            begin
                in_frame    = 1'b1;
                char_count  = '0;
                high_nibble = '0;
                byte_sum    = '0;
                byte_count  = '0;
                halted      = 1'b0;
            end
            if (!in_frame || int'(char_count) >= FRAME_BUF - 2)
            begin
                return;
            end
            pos        = char_count;
            char_count = char_count + 8'd1;
            if (pos == 8'd1)
            begin
                second_char = c;
            end
            // even positions carry the high nibble, odd ones complete a byte
            if (!halted)
            begin
                if (!pos[0])
                begin
                    if (c == CH_NEWLINE || c == CH_NUL)
                    begin
                        halted = 1'b1;
                    end
                    else
                    begin
                        high_nibble = digit_value(c);
                    end
                end
                else
                begin
                    b = {high_nibble, digit_value(c)};
                    if (byte_count < HEAD_DEPTH)
                    begin
                        head[byte_count[HEAD_W-1:0]] = b;
                    end
                    byte_sum   = byte_sum + b;
                    byte_count = byte_count + 7'd1;
                end
            end
            if (c != CH_NEWLINE)
            begin
                return;
            end
            in_frame = 1'b0;
            if (second_char != CH_ASYNC && byte_sum == SUM_MATCH && byte_count != 0)
            begin
                r.command     = head[0];
                r.register_id = {head[2], head[1]};
                r.flags       = head[3];
                r.value       = {head[7], head[6], head[5], head[4]};
                r.payload_len = byte_count - 7'd1;
                expected_frames.push_back(r);
            end
        endfunction

        // Compare one result word with the oldest expected frame
        task check_frame(frame_result_t got);
            frame_result_t exp;
            if (expected_frames.size() == 0)
            begin
                report($sformatf("unexpected result, command %h", got.command));
                return;
            end
            exp = expected_frames.pop_front();
            frames_checked++;
            if (got.command !== exp.command)
            begin
                report($sformatf("command %h, want %h", got.command, exp.command));
            end
            if (got.register_id !== exp.register_id)
            begin
                report($sformatf("register_id %h, want %h", got.register_id,
                                 exp.register_id));
            end
            if (got.flags !== exp.flags)
            begin
                report($sformatf("flags %h, want %h", got.flags, exp.flags));
            end
            if (got.value !== exp.value)
            begin
                report($sformatf("value %h, want %h", got.value, exp.value));
            end
            if (got.payload_len !== exp.payload_len)
            begin
                report($sformatf("payload_len %0d, want %0d", got.payload_len,
                                 exp.payload_len));
            end
        endtask
    endclass

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        in_valid  = 1'b0;
    logic [7:0]  rx_char   = '0;
    logic        out_ready = 1'b0;
    logic        in_ready;
    logic        out_valid;
    logic [7:0]  command;
    logic [15:0] register_id;
    logic [7:0]  flags;
    logic [31:0] value;
    logic [6:0]  payload_len;

    frame_scoreboard sb = new();
    int              chars_sent  = 0;
    int              cycle_count = 0;

    hex_ascii_frame_decoder #(
        .BUFFER_BYTES (FRAME_BUF)
    ) u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .rx_char     (rx_char),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .command     (command),
        .register_id (register_id),
        .flags       (flags),
        .value       (value),
        .payload_len (payload_len)
    );

    // 2 ns clock
    always
    begin
        clk = 1'b1;
        #1;
        clk = 1'b0;
        #1;
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // Monitor: check results before noting the new input word
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                sb.check_frame({command, register_id, flags, value, payload_len});
            end
            if (in_valid && in_ready)
            begin
                sb.predict_char(rx_char);
            end
        end
    end

    // Receiver: random stalls, one long hold-off, a calm window
    initial
    begin
        bit held;
        held = 1'b0;
        @(posedge clk iff rst_n);
        forever
        begin
            if (!held && sb.chars_noted >= HOLD_AT)
            begin
                held = 1'b1;
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else
            begin
                if (sb.chars_noted >= CALM_LO && sb.chars_noted < CALM_HI)
                begin
                    out_ready <= 1'b1;
                end
                else
                begin
                    out_ready <= ($urandom_range(99) >= IDLE_PCT);
                end
                @(posedge clk);
            end
        end
    end

    function automatic logic [7:0] hex_char(logic [3:0] d);
        return (d < 4'd10) ? CH_DIGIT0 + 8'(d) : CH_LETTERA + 8'(d) - 8'd10;
    endfunction

    // Offer one character word and hold it until taken
    task automatic send_char(logic [7:0] c);
        bit calm;
        calm = (chars_sent >= CALM_LO && chars_sent < CALM_HI);
        while (!calm && $urandom_range(99) < IDLE_PCT)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        rx_char  <= c;
        do
        begin
            @(posedge clk);
        end
        while (!in_ready);
        chars_sent++;
    endtask

    task automatic send_text(string s);
        for (int i = 0; i < s.len(); i++)
        begin
            send_char(s[i]);
        end
    endtask

    // Build a frame whose bytes sum to the match value, optionally spoiled
    task automatic send_frame(int n_bytes, bit odd_end, bit async_tag, bit spoil);
        logic [7:0] bytes[$];
        logic [7:0] chars[$];
        logic [7:0] rest;
        int         fix;
        for (int i = 0; i < n_bytes; i++)
        begin
            bytes.push_back(8'($urandom_range(255)));
        end
        // the colon is the first high nibble
        bytes[0] = async_tag ? 8'd10 : 8'($urandom_range(15));
        if (odd_end)
        begin
            bytes[n_bytes - 1][3:0] = 4'd0;
        end
        fix  = odd_end ? 1 : n_bytes - 1;
        rest = '0;
        for (int i = 0; i < n_bytes; i++)
        begin
            if (i != fix)
            begin
                rest += bytes[i];
            end
        end
        bytes[fix] = SUM_MATCH - rest;
        chars.push_back(CH_COLON);
        chars.push_back(hex_char(bytes[0][3:0]));
        for (int i = 1; i < n_bytes; i++)
        begin
            chars.push_back(hex_char(bytes[i][7:4]));
            if (!(odd_end && i == n_bytes - 1))
            begin
                chars.push_back(hex_char(bytes[i][3:0]));
            end
        end
        if (spoil)
        begin
            chars[$urandom_range(chars.size() - 1, 1)] = 8'($urandom_range(255));
        end
        foreach (chars[i])
        begin
            send_char(chars[i]);
        end
        send_char(CH_NEWLINE);
    endtask

    // Stimulus and end of run
    initial
    begin
        int  pick;
        int  n;
        int  guard;
        bit  paused;
        paused = 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: outside-frame noise, plain frame, async tag, restart with odd
        // count and stale head bytes, NUL as high nibble, NUL as low nibble
        send_char(CH_TOP);
        send_text(":055");
        send_char(CH_NEWLINE);
        send_text(":A4B");
        send_char(CH_NEWLINE);
        send_text(":9:55");
        send_char(CH_NEWLINE);
        send_text(":0");
        send_char(CH_NUL);
        send_text("55");
        send_char(CH_NEWLINE);
        send_text(":05");
        send_char(CH_NUL);
        send_char(CH_NEWLINE);

        // random frames, mostly well formed
        while (chars_sent < CHAR_TARGET)
        begin
            if (!paused && chars_sent >= QUIET_AT)
            begin
                paused = 1'b1;
                in_valid <= 1'b0;
                do
                begin
                    @(posedge clk);
                end
                while (sb.expected_frames.size() != 0);
            end
            pick = $urandom_range(99);
            n    = ($urandom_range(9) == 0) ? $urandom_range(34, 11) : $urandom_range(10, 3);
            if (pick < 55)
            begin
                send_frame(n, 1'b0, 1'b0, 1'b0);
            end
            else if (pick < 70)
            begin
                send_frame(n, 1'b1, 1'b0, 1'b0);
            end
            else if (pick < 77)
            begin
                send_frame(n, $urandom_range(1), 1'b1, 1'b0);
            end
            else if (pick < 90)
            begin
                send_frame(n, $urandom_range(1), 1'b0, 1'b1);
            end
            else
            begin
                repeat ($urandom_range(4, 1))
                begin
                    send_char(8'($urandom_range(255)));
                end
            end
        end
        in_valid <= 1'b0;

        // drain
        guard = 0;
        while (sb.expected_frames.size() != 0 && guard < 5000)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (8) @(posedge clk);
        while (sb.expected_frames.size() != 0)
        begin
            sb.report($sformatf("frame never came out, command %h",
                                sb.expected_frames[0].command));
            void'(sb.expected_frames.pop_front());
        end

        $display("Sent %0d characters in colon-to-newline frames, clean and spoiled.",
                 chars_sent);
        $display("Checked %0d decoded frames, %0d mismatches.", sb.frames_checked,
                 sb.errors);
        if (sb.errors == 0)
        begin
            $display("Test completed successfully");
        end
        else
        begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
